// ===== rtl/mlss_pkg.sv =====
// ----------------------------------------------------------------------------
// mlss_pkg
// Shared constants and types for the motor limit safety supervisor: register
// map, command and state codes, reset values and the structs between modules.
// ----------------------------------------------------------------------------
package mlss_pkg;

   // configuration port address width (seven 32-bit registers)
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   // register indexes (byte address is 4 times the index)
   localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED     = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_MAX_POSITION  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_MIN_POSITION  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_POS_CHECK_EN  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_FAULT_CONFIRM = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_SHUTDOWN      = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_RESTART_DELAY = 3'd6;

   // command codes
   localparam logic [1:0] CMD_TICK      = 2'd0;
   localparam logic [1:0] CMD_EMERGENCY = 2'd1;
   localparam logic [1:0] CMD_CLEAR     = 2'd2;

   // safety state codes
   localparam logic [2:0] ST_NORMAL         = 3'd0;
   localparam logic [2:0] ST_SPEED_LIMIT    = 3'd1;
   localparam logic [2:0] ST_POSITION_LIMIT = 3'd2;
   localparam logic [2:0] ST_EMERGENCY      = 3'd3;
   localparam logic [2:0] ST_RECOVERING     = 3'd4;

   // register reset values
   localparam logic [30:0]        RST_MAX_SPEED     = 31'h7FFF_FFFF;
   localparam logic signed [31:0] RST_MAX_POSITION  = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] RST_MIN_POSITION  = 32'sh8000_0000;
   localparam logic               RST_POS_CHECK_EN  = 1'b1;
   localparam logic [15:0]        RST_FAULT_CONFIRM = 16'd100;
   localparam logic [15:0]        RST_SHUTDOWN      = 16'd1000;
   localparam logic [15:0]        RST_RESTART_DELAY = 16'd1000;

   typedef struct packed {
      logic [30:0]        max_speed;
      logic signed [31:0] max_position;
      logic signed [31:0] min_position;
      logic               position_check_enable;
      logic [15:0]        fault_confirm_ms;
      logic [15:0]        shutdown_ms;
      logic [15:0]        restart_delay_ms;
   } mlss_cfg_type;

   typedef struct packed {
      logic [2:0] safety_state;
      logic       motor_stop;
      logic       is_safe;
      logic       is_shutdown;
   } mlss_result_type;

endpackage

// ===== rtl/mlss_csr.sv =====
// ----------------------------------------------------------------------------
// mlss_csr
// Configuration register file behind an APB-style port. Zero wait states;
// writes land on the access cycle, reads return the addressed register.
// ----------------------------------------------------------------------------
module mlss_csr
   import mlss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output mlss_cfg_type          cfg
);

   mlss_cfg_type          cfg_ff;
   mlss_cfg_type          cfg_in;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_MAX_SPEED:     cfg_in.max_speed             = csr_pwdata[30:0];
            REG_MAX_POSITION:  cfg_in.max_position          = csr_pwdata;
            REG_MIN_POSITION:  cfg_in.min_position          = csr_pwdata;
            REG_POS_CHECK_EN:  cfg_in.position_check_enable = csr_pwdata[0];
            REG_FAULT_CONFIRM: cfg_in.fault_confirm_ms      = csr_pwdata[15:0];
            REG_SHUTDOWN:      cfg_in.shutdown_ms           = csr_pwdata[15:0];
            REG_RESTART_DELAY: cfg_in.restart_delay_ms      = csr_pwdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_speed             <= RST_MAX_SPEED;
         cfg_ff.max_position          <= RST_MAX_POSITION;
         cfg_ff.min_position          <= RST_MIN_POSITION;
         cfg_ff.position_check_enable <= RST_POS_CHECK_EN;
         cfg_ff.fault_confirm_ms      <= RST_FAULT_CONFIRM;
         cfg_ff.shutdown_ms           <= RST_SHUTDOWN;
         cfg_ff.restart_delay_ms      <= RST_RESTART_DELAY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_MAX_SPEED:     csr_prdata = {1'b0, cfg_ff.max_speed};
         REG_MAX_POSITION:  csr_prdata = cfg_ff.max_position;
         REG_MIN_POSITION:  csr_prdata = cfg_ff.min_position;
         REG_POS_CHECK_EN:  csr_prdata = {31'd0, cfg_ff.position_check_enable};
         REG_FAULT_CONFIRM: csr_prdata = {16'd0, cfg_ff.fault_confirm_ms};
         REG_SHUTDOWN:      csr_prdata = {16'd0, cfg_ff.shutdown_ms};
         REG_RESTART_DELAY: csr_prdata = {16'd0, cfg_ff.restart_delay_ms};
         default:           csr_prdata = '0;
      endcase
   end

endmodule

// ===== rtl/mlss_supervisor.sv =====
// ----------------------------------------------------------------------------
// mlss_supervisor
// Supervisor state and its single-pass update: emergency service, shutdown
// hold and recovery timing, and the speed and position limit checks.
// ----------------------------------------------------------------------------
module mlss_supervisor
   import mlss_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic [1:0]         cmd,
   input  logic [31:0]        now_ms,
   input  logic signed [31:0] position,
   input  logic signed [31:0] speed,
   input  logic               position_mode,
   input  mlss_cfg_type       cfg,
   output mlss_result_type    result
);

   logic [2:0]  cur_state_ff,  cur_state_in;
   logic        emerg_pend_ff, emerg_pend_in;
   logic        shut_down_ff,  shut_down_in;
   logic        fault_vld_ff,  fault_vld_in;
   logic        shdn_vld_ff,   shdn_vld_in;
   logic [31:0] fault_start_ff, fault_start_in;
   logic [31:0] shdn_start_ff,  shdn_start_in;

   logic [31:0] shdn_elapsed;
   logic [31:0] fault_elapsed;
   logic [31:0] speed_mag;
   logic [16:0] restart_limit;
   logic        speed_fault;
   logic        pos_fault;
   logic [2:0]  fault_code;
   logic        stop;

   // elapsed times, zero when the start mark is not valid
   assign shdn_elapsed  = shdn_vld_ff  ? (now_ms - shdn_start_ff)  : 32'd0;
   assign fault_elapsed = fault_vld_ff ? (now_ms - fault_start_ff) : 32'd0;
   assign restart_limit = {1'b0, cfg.shutdown_ms} + {1'b0, cfg.restart_delay_ms};

   // limit checks; the magnitude of the most negative speed is 2^31
   assign speed_mag   = speed[31] ? (~speed + 32'd1) : speed;
   assign speed_fault = speed_mag > {1'b0, cfg.max_speed};
   assign pos_fault   = cfg.position_check_enable &&
                        ((position < cfg.min_position) || (position > cfg.max_position));
   assign fault_code  = pos_fault ? ST_POSITION_LIMIT :
                        speed_fault ? ST_SPEED_LIMIT : ST_NORMAL;

   // next state for one transaction
   always_comb begin
      cur_state_in   = cur_state_ff;
      emerg_pend_in  = emerg_pend_ff;
      shut_down_in   = shut_down_ff;
      fault_vld_in   = fault_vld_ff;
      shdn_vld_in    = shdn_vld_ff;
      fault_start_in = fault_start_ff;
      shdn_start_in  = shdn_start_ff;
      stop           = 1'b0;
      case (cmd)
         CMD_EMERGENCY: begin
            emerg_pend_in = 1'b1;
         end
         CMD_CLEAR: begin
            if (shut_down_ff) begin
               cur_state_in  = ST_NORMAL;
               emerg_pend_in = 1'b0;
               shut_down_in  = 1'b0;
               fault_vld_in  = 1'b0;
               shdn_vld_in   = 1'b0;
            end
         end
         CMD_TICK: begin
            if (emerg_pend_ff) begin
               cur_state_in  = ST_EMERGENCY;
               stop          = 1'b1;
               shut_down_in  = 1'b1;
               shdn_start_in = now_ms;
               shdn_vld_in   = 1'b1;
               emerg_pend_in = 1'b0;
            end else if (shut_down_ff) begin
               if (shdn_elapsed < {16'd0, cfg.shutdown_ms}) begin
                  stop = 1'b1;
               end else begin
                  cur_state_in = ST_RECOVERING;
                  if ((shdn_elapsed >= {15'd0, restart_limit}) && position_mode) begin
                     shut_down_in = 1'b0;
                     cur_state_in = ST_NORMAL;
                     fault_vld_in = 1'b0;
                  end
               end
            end else if (position_mode && (fault_code != ST_NORMAL)) begin
               if (cur_state_ff == fault_code) begin
                  if (fault_elapsed >= {16'd0, cfg.fault_confirm_ms}) begin
                     stop          = 1'b1;
                     shut_down_in  = 1'b1;
                     shdn_start_in = now_ms;
                     shdn_vld_in   = 1'b1;
                  end
               end else begin
                  fault_start_in = now_ms;
                  fault_vld_in   = 1'b1;
                  cur_state_in   = fault_code;
               end
            end else begin
               cur_state_in = ST_NORMAL;
               fault_vld_in = 1'b0;
            end
         end
         default: begin
            cur_state_in = cur_state_ff;
         end
      endcase
   end

   // result reflects the state after the transaction
   assign result.safety_state = cur_state_in;
   assign result.motor_stop   = stop;
   assign result.is_safe      = (cur_state_in == ST_NORMAL) && !shut_down_in;
   assign result.is_shutdown  = shut_down_in;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_state_ff  <= ST_NORMAL;
         emerg_pend_ff <= 1'b0;
         shut_down_ff  <= 1'b0;
         fault_vld_ff  <= 1'b0;
         shdn_vld_ff   <= 1'b0;
      end else if (step_en) begin
         cur_state_ff  <= cur_state_in;
         emerg_pend_ff <= emerg_pend_in;
         shut_down_ff  <= shut_down_in;
         fault_vld_ff  <= fault_vld_in;
         shdn_vld_ff   <= shdn_vld_in;
      end
   end

   // timestamps, qualified by their valid flags
   always_ff @(posedge clock) begin
      if (step_en) begin
         fault_start_ff <= fault_start_in;
         shdn_start_ff  <= shdn_start_in;
      end
   end

endmodule

// ===== rtl/motor_limit_safety_supervisor_core.sv =====
// ----------------------------------------------------------------------------
// motor_limit_safety_supervisor_core
// Top level: request register, supervisor update and response register.
// ----------------------------------------------------------------------------
// Takes one command transaction per clock cycle while rsp_ready stays high
// and returns exactly one response per command. A request is captured in an
// input register, the supervisor state is updated by a single pass of compare
// and subtract logic, and the response lands in an output register, so
// sustained throughput is one transaction per cycle as long as rsp_ready stays
// high. While a response waits, the request register can still take one more
// transaction, after which req_ready stays low until the response is taken.
// Limits and timing are set through the APB-style csr_ port (registers at byte
// addresses 0x00 to 0x18) and should be written only while no transaction is
// in flight.
module motor_limit_safety_supervisor_core
   import mlss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic [31:0]           req_now_ms,
   input  logic signed [31:0]    req_position,
   input  logic signed [31:0]    req_speed,
   input  logic                  req_position_mode,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_safety_state,
   output logic                  rsp_motor_stop,
   output logic                  rsp_is_safe,
   output logic                  rsp_is_shutdown,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   mlss_cfg_type       cfg;
   mlss_result_type    step_result;

   logic               in_vld_ff,  in_vld_in;
   logic [1:0]         in_cmd_ff;
   logic [31:0]        in_now_ff;
   logic signed [31:0] in_pos_ff;
   logic signed [31:0] in_spd_ff;
   logic               in_pmode_ff;
   logic               rsp_vld_ff, rsp_vld_in;
   mlss_result_type    rsp_ff;
   logic               advance;
   logic               req_take;

   mlss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mlss_supervisor u_supervisor (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .cmd           (in_cmd_ff),
      .now_ms        (in_now_ff),
      .position      (in_pos_ff),
      .speed         (in_spd_ff),
      .position_mode (in_pmode_ff),
      .cfg           (cfg),
      .result        (step_result)
   );

   // pipeline flow control
   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_vld_in  = req_take || (in_vld_ff && !advance);
   assign rsp_vld_in = advance || (rsp_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // request payload register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff   <= req_cmd;
         in_now_ff   <= req_now_ms;
         in_pos_ff   <= req_position;
         in_spd_ff   <= req_speed;
         in_pmode_ff <= req_position_mode;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_safety_state = rsp_ff.safety_state;
   assign rsp_motor_stop   = rsp_ff.motor_stop;
   assign rsp_is_safe      = rsp_ff.is_safe;
   assign rsp_is_shutdown  = rsp_ff.is_shutdown;

endmodule

// ===== dv/tb_motor_limit_safety_supervisor_core.sv =====
// ----------------------------------------------------------------------------
// tb_motor_limit_safety_supervisor_core
// Self-checking bench for the motor limit safety supervisor. A queue-fed
// driver sends command transactions and a status predictor computes the
// expected response for each one. A monitor checks every response field by
// field. The limits are reprogrammed over the csr_ port between phases, and
// both sides apply random idle cycles, one long receiver hold and some
// stretches at full rate.
// ----------------------------------------------------------------------------
module tb_motor_limit_safety_supervisor_core
   import mlss_pkg::*;
();

   // command code the block ignores
   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int         QUIET_LIMIT = 2000;
   localparam int         LONG_HOLD   = 300;
   localparam int         PHASE_CMDS  = 80;

   typedef struct {
      logic [1:0]         cmd;
      logic [31:0]        now_ms;
      logic signed [31:0] position;
      logic signed [31:0] speed;
      logic               position_mode;
   } supervisor_cmd_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_cmd = CMD_TICK;
   logic [31:0]           req_now_ms = '0;
   logic signed [31:0]    req_position = '0;
   logic signed [31:0]    req_speed = '0;
   logic                  req_position_mode = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [2:0]            rsp_safety_state;
   logic                  rsp_motor_stop;
   logic                  rsp_is_safe;
   logic                  rsp_is_shutdown;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   motor_limit_safety_supervisor_core dut (.*);

   // predictor copy of the limit registers
   logic [30:0]        lim_max_speed = RST_MAX_SPEED;
   logic signed [31:0] lim_max_pos   = RST_MAX_POSITION;
   logic signed [31:0] lim_min_pos   = RST_MIN_POSITION;
   logic               pos_check_on  = RST_POS_CHECK_EN;
   logic [15:0]        confirm_ms    = RST_FAULT_CONFIRM;
   logic [15:0]        hold_ms       = RST_SHUTDOWN;
   logic [15:0]        restart_ms    = RST_RESTART_DELAY;

   // predictor copy of the supervisor state
   logic [2:0]  state_q       = ST_NORMAL;
   logic        estop_pending = 1'b0;
   logic        halted        = 1'b0;
   logic [31:0] fault_t0      = '0;
   logic        fault_t0_ok   = 1'b0;
   logic [31:0] halt_t0       = '0;
   logic        halt_t0_ok    = 1'b0;

   supervisor_cmd_type cmd_backlog[$];
   supervisor_cmd_type cmd_on_bus;
   mlss_result_type    expected_status[$];

   int          send_wait = 0;
   int          stall_left = 0;
   int          rsp_draw;
   int          rsp_hold_asked = 0;
   int          rsp_hold_served = 0;
   int          quiet_cycles = 0;
   int          errors = 0;
   int          cmds_taken = 0;
   int          rsp_checked = 0;
   int          stim_count = 0;
   int          stop_pulses = 0;
   int          restarts = 0;
   int          settings_count = 0;
   int          now_step_max = 4;
   logic [31:0] now_cursor = '0;
   bit          sender_idle_on = 1'b1;
   bit          receiver_idle_on = 1'b1;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int draw_wait(input bit idling);
      return idling ? int'($urandom_range(0, 12)) : 0;
   endfunction

   // expected response of the supervisor for one command, advancing its state
   function automatic mlss_result_type predict_status(input supervisor_cmd_type c);
      mlss_result_type r;
      logic [31:0]     span;
      logic [31:0]     mag;
      logic [2:0]      fault;
      logic            stop;
      stop = 1'b0;
      case (c.cmd)
         CMD_EMERGENCY: estop_pending = 1'b1;
         CMD_CLEAR: begin
            // clear only acts on a shut-down motor
            if (halted) begin
               state_q       = ST_NORMAL;
               estop_pending = 1'b0;
               halted        = 1'b0;
               fault_t0      = '0;
               fault_t0_ok   = 1'b0;
               halt_t0       = '0;
               halt_t0_ok    = 1'b0;
            end
         end
         CMD_TICK: begin
            if (estop_pending) begin
               state_q       = ST_EMERGENCY;
               stop          = 1'b1;
               halted        = 1'b1;
               halt_t0       = c.now_ms;
               halt_t0_ok    = 1'b1;
               estop_pending = 1'b0;
            end else if (halted) begin
               // hold, then recovering, then restart in position mode
               span = halt_t0_ok ? c.now_ms - halt_t0 : 32'd0;
               if (span < {16'd0, hold_ms}) begin
                  stop = 1'b1;
               end else begin
                  state_q = ST_RECOVERING;
                  if (span >= {16'd0, hold_ms} + {16'd0, restart_ms} && c.position_mode) begin
                     halted      = 1'b0;
                     state_q     = ST_NORMAL;
                     fault_t0    = '0;
                     fault_t0_ok = 1'b0;
                     restarts++;
                  end
               end
            end else if (c.position_mode) begin
               // |speed| as unsigned, so the most negative speed gives 2^31
               mag   = c.speed[31] ? -c.speed : c.speed;
               fault = ST_NORMAL;
               if (mag > {1'b0, lim_max_speed}) fault = ST_SPEED_LIMIT;
               if (pos_check_on && (c.position < lim_min_pos || c.position > lim_max_pos))
                  fault = ST_POSITION_LIMIT;
               if (fault != ST_NORMAL) begin
                  if (state_q == fault) begin
                     span = fault_t0_ok ? c.now_ms - fault_t0 : 32'd0;
                     if (span >= {16'd0, confirm_ms}) begin
                        stop       = 1'b1;
                        halted     = 1'b1;
                        halt_t0    = c.now_ms;
                        halt_t0_ok = 1'b1;
                     end
                  end else begin
                     fault_t0    = c.now_ms;
                     fault_t0_ok = 1'b1;
                     state_q     = fault;
                  end
               end else begin
                  state_q     = ST_NORMAL;
                  fault_t0    = '0;
                  fault_t0_ok = 1'b0;
               end
            end else begin
               state_q     = ST_NORMAL;
               fault_t0    = '0;
               fault_t0_ok = 1'b0;
            end
         end
         default: ;
      endcase
      if (stop) stop_pulses++;
      r.safety_state = state_q;
      r.motor_stop   = stop;
      r.is_safe      = (state_q == ST_NORMAL) && !halted;
      r.is_shutdown  = halted;
      return r;
   endfunction

   // driver: one transaction per handshake, random gap before the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_status.push_back(predict_status(cmd_on_bus));
            cmds_taken++;
         end
         if (req_valid && !req_ready) begin
            // hold the offered transaction
         end else if (send_wait > 0) begin
            req_valid <= 1'b0;
            send_wait <= send_wait - 1;
         end else if (cmd_backlog.size() != 0) begin
            cmd_on_bus = cmd_backlog.pop_front();
            req_valid         <= 1'b1;
            req_cmd           <= cmd_on_bus.cmd;
            req_now_ms        <= cmd_on_bus.now_ms;
            req_position      <= cmd_on_bus.position;
            req_speed         <= cmd_on_bus.speed;
            req_position_mode <= cmd_on_bus.position_mode;
            send_wait         <= draw_wait(sender_idle_on);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic check_status();
      mlss_result_type want;
      if (expected_status.size() == 0) begin
         $error("response with nothing outstanding: safety_state %0d", rsp_safety_state);
         errors++;
      end else begin
         want = expected_status.pop_front();
         rsp_checked++;
         if (rsp_safety_state !== want.safety_state) begin
            $error("safety_state expected %0d actual %0d", want.safety_state, rsp_safety_state);
            errors++;
         end
         if (rsp_motor_stop !== want.motor_stop) begin
            $error("motor_stop expected %0d actual %0d", want.motor_stop, rsp_motor_stop);
            errors++;
         end
         if (rsp_is_safe !== want.is_safe) begin
            $error("is_safe expected %0d actual %0d", want.is_safe, rsp_is_safe);
            errors++;
         end
         if (rsp_is_shutdown !== want.is_shutdown) begin
            $error("is_shutdown expected %0d actual %0d", want.is_shutdown, rsp_is_shutdown);
            errors++;
         end
      end
   endtask

   // monitor: check responses, random stalls and the long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) check_status();
         if (rsp_hold_asked != rsp_hold_served) begin
            rsp_hold_served <= rsp_hold_asked;
            stall_left      <= LONG_HOLD;
            rsp_ready       <= 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            rsp_draw = draw_wait(receiver_idle_on);
            if (rsp_draw == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready  <= 1'b0;
               stall_left <= rsp_draw;
            end
         end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
         end else begin
            stall_left <= 0;
            rsp_ready  <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_motor_limit_safety_supervisor_core: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      // register takes the value at the access edge
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_MAX_SPEED:     lim_max_speed = data[30:0];
         REG_MAX_POSITION:  lim_max_pos   = data;
         REG_MIN_POSITION:  lim_min_pos   = data;
         REG_POS_CHECK_EN:  pos_check_on  = data[0];
         REG_FAULT_CONFIRM: confirm_ms    = data[15:0];
         REG_SHUTDOWN:      hold_ms       = data[15:0];
         REG_RESTART_DELAY: restart_ms    = data[15:0];
         default: ;
      endcase
   endtask

   // program all limits; unused upper bits carry noise
   task automatic set_limits(input logic [30:0] spd_max, input logic [31:0] pos_max,
                             input logic [31:0] pos_min, input logic chk_en,
                             input logic [15:0] fc, input logic [15:0] sd,
                             input logic [15:0] rd);
      csr_write(REG_MAX_SPEED, {1'($urandom), spd_max});
      csr_write(REG_MAX_POSITION, pos_max);
      csr_write(REG_MIN_POSITION, pos_min);
      csr_write(REG_POS_CHECK_EN, {31'($urandom), chk_en});
      csr_write(REG_FAULT_CONFIRM, {16'($urandom), fc});
      csr_write(REG_SHUTDOWN, {16'($urandom), sd});
      csr_write(REG_RESTART_DELAY, {16'($urandom), rd});
      now_step_max = (fc + sd + rd) / 6 + 2;
      settings_count++;
   endtask

   // wait until every response is back, then a short settle
   task automatic drain();
      while (cmd_backlog.size() != 0 || req_valid || expected_status.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic queue_cmd(input logic [1:0] cmd, input logic [31:0] now,
                            input logic [31:0] pos, input logic [31:0] spd,
                            input logic pmode);
      supervisor_cmd_type c;
      c.cmd           = cmd;
      c.now_ms        = now;
      c.position      = pos;
      c.speed         = spd;
      c.position_mode = pmode;
      cmd_backlog.push_back(c);
      if (cmd != CMD_UNUSED) stim_count++;
   endtask

   // position inside or outside the programmed window, boundaries favored
   function automatic logic signed [31:0] pick_position(input bit outside);
      longint      lo;
      longint      hi;
      int unsigned span;
      lo = lim_min_pos;
      hi = lim_max_pos;
      if (!outside) begin
         if (lo > hi) return $urandom;
         span = 32'(hi - lo);
         case ($urandom_range(0, 5))
            0: return 32'(lo);
            1: return 32'(hi);
            default: return 32'(lo + $urandom_range(0, span));
         endcase
      end
      if (lo > -64'sd2147483648 && (hi == 64'sd2147483647 || $urandom_range(0, 1) == 1)) begin
         span = 32'(lo + 64'sd2147483647);
         return 32'((lo - 1) - (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, span)));
      end
      if (hi < 64'sd2147483647) begin
         span = 32'(64'sd2147483646 - hi);
         return 32'((hi + 1) + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, span)));
      end
      return $urandom;
   endfunction

   // speed within or beyond the limit, either sign
   function automatic logic signed [31:0] pick_speed(input bit too_fast);
      int unsigned mag;
      if (!too_fast)
         mag = ($urandom_range(0, 3) == 0) ? {1'b0, lim_max_speed} :
               $urandom_range(0, lim_max_speed);
      else if (lim_max_speed == 31'h7FFF_FFFF)
         return 32'sh8000_0000;
      else if ($urandom_range(0, 3) == 0)
         mag = lim_max_speed + 32'd1;
      else
         mag = $urandom_range(lim_max_speed + 32'd1, 32'h8000_0000);
      if (mag == 32'h8000_0000) return 32'sh8000_0000;
      return ($urandom_range(0, 1) == 1) ? -mag : mag;
   endfunction

   // a run of commands with a persistent fault regime and some noise
   task automatic queue_burst(input int count);
      int          regime;
      int          pick;
      int          roll;
      logic [1:0]  cmd;
      logic [31:0] pos;
      logic [31:0] spd;
      regime = $urandom_range(0, 3);
      repeat (count) begin
         if ($urandom_range(0, 99) < 3) now_cursor = $urandom;
         else now_cursor = now_cursor + $urandom_range(0, now_step_max);
         roll = $urandom_range(0, 99);
         cmd  = (roll < 80) ? CMD_TICK : (roll < 87) ? CMD_EMERGENCY :
                (roll < 95) ? CMD_CLEAR : CMD_UNUSED;
         pick = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : regime;
         pos  = pick_position(pick[1]);
         spd  = pick_speed(pick[0]);
         if ($urandom_range(0, 19) == 0) begin
            pos = $urandom;
            spd = $urandom;
         end
         queue_cmd(cmd, now_cursor, pos, spd, $urandom_range(0, 9) != 0);
      end
   endtask

   initial begin
      int          ph;
      int          first;
      logic [30:0] ms;
      logic [31:0] mxp;
      logic [31:0] mnp;
      logic        en;
      logic [15:0] fc;
      logic [15:0] sd;
      logic [15:0] rd;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset limits, speed fault, emergency, hold, recovery, wrap
      queue_cmd(CMD_TICK, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      queue_cmd(CMD_UNUSED, 32'd1, 32'd0, 32'd0, 1'b1);
      queue_cmd(CMD_TICK, 32'd10, 32'h8000_0000, 32'h8000_0000, 1'b1);
      queue_cmd(CMD_TICK, 32'd110, 32'd0, 32'h8000_0000, 1'b1);
      queue_cmd(CMD_TICK, 32'd500, 32'd0, 32'd0, 1'b1);
      queue_cmd(CMD_CLEAR, 32'd600, 32'd0, 32'd0, 1'b1);
      queue_cmd(CMD_EMERGENCY, 32'd700, 32'd0, 32'd0, 1'b1);
      queue_cmd(CMD_CLEAR, 32'd710, 32'd0, 32'd0, 1'b1);
      queue_cmd(CMD_TICK, 32'd720, 32'd0, 32'd0, 1'b0);
      queue_cmd(CMD_TICK, 32'd1720, 32'd0, 32'd0, 1'b1);
      queue_cmd(CMD_TICK, 32'd2719, 32'd0, 32'd0, 1'b1);
      queue_cmd(CMD_TICK, 32'd2720, 32'd0, 32'd0, 1'b0);
      queue_cmd(CMD_TICK, 32'd2721, 32'd0, 32'd0, 1'b1);
      queue_cmd(CMD_TICK, 32'd2730, 32'd0, 32'h8000_0000, 1'b0);
      queue_cmd(CMD_TICK, 32'hFFFF_FFF0, 32'd0, 32'h8000_0000, 1'b1);
      queue_cmd(CMD_TICK, 32'h0000_0050, 32'd0, 32'h8000_0000, 1'b1);
      queue_cmd(CMD_TICK, 32'h0000_0054, 32'd0, 32'h8000_0000, 1'b1);
      queue_cmd(CMD_EMERGENCY, 32'h0000_0060, 32'd0, 32'd0, 1'b1);
      queue_cmd(CMD_TICK, 32'h0000_0061, 32'd0, 32'd0, 1'b1);
      queue_cmd(CMD_CLEAR, 32'h0000_0070, 32'd0, 32'd0, 1'b1);
      drain();

      // directed: tight window, zero times, position priority and kind change
      set_limits(31'd0, 32'd100, -32'sd100, 1'b1, 16'd0, 16'd0, 16'd0);
      @(negedge clock);
      queue_cmd(CMD_TICK, 32'd10, 32'd200, 32'hFFFF_FFFF, 1'b1);
      queue_cmd(CMD_TICK, 32'd11, 32'd50, 32'hFFFF_FFFF, 1'b1);
      queue_cmd(CMD_TICK, 32'd11, 32'd100, 32'hFFFF_FFFF, 1'b1);
      queue_cmd(CMD_TICK, 32'd11, 32'd0, 32'd0, 1'b1);
      queue_cmd(CMD_TICK, 32'd12, -32'sd101, 32'd0, 1'b1);
      drain();
      now_cursor = $urandom;

      // random phases over a spread of limit settings
      for (ph = 0; ph < 8; ph++) begin
         ms  = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h0040_0000));
         mnp = -$urandom_range(0, 32'h0100_0000);
         mxp = $urandom_range(0, 32'h0100_0000);
         if ($urandom_range(0, 3) == 0) begin
            mnp = $urandom;
            mxp = $urandom;
         end
         en = ($urandom_range(0, 3) != 0);
         fc = 16'($urandom_range(0, 40));
         sd = 16'($urandom_range(0, 60));
         rd = 16'($urandom_range(0, 60));
         case (ph)
            0: begin
               ms = '0; mxp = '0; mnp = '0; en = 1'b1; fc = '0; sd = '0; rd = '0;
            end
            1: begin
               ms = RST_MAX_SPEED; mxp = RST_MAX_POSITION; mnp = RST_MIN_POSITION;
               en = 1'b1; fc = 16'hFFFF; sd = 16'hFFFF; rd = 16'hFFFF;
            end
            2: begin
               mnp = 32'd1000; mxp = -32'sd1000; en = 1'b1;
            end
            5: en = 1'b0;
            default: ;
         endcase
         set_limits(ms, mxp, mnp, en, fc, sd, rd);
         @(negedge clock);
         sender_idle_on   = !(ph == 3 || ph == 6);
         receiver_idle_on = !(ph == 2 || ph == 6);
         // receiver holds off while the sender keeps offering
         if (ph == 3) rsp_hold_asked++;
         first = stim_count;
         while (stim_count - first < PHASE_CMDS) queue_burst($urandom_range(3, 16));
         drain();
      end

      repeat (10) @(posedge clock);
      if (expected_status.size() != 0) begin
         $error("%0d responses never arrived", expected_status.size());
         errors++;
      end
      $display("covered %0d commands over %0d limit settings: %0d stop pulses, %0d restarts",
               cmds_taken, settings_count, stop_pulses, restarts);
      $display("checked %0d responses under random idling, a long receiver hold and full rate",
               rsp_checked);
      if (errors == 0) begin
         $display("tb_motor_limit_safety_supervisor_core: clean");
      end else begin
         $display("tb_motor_limit_safety_supervisor_core: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/mlss_pkg.sv
rtl/mlss_csr.sv
rtl/mlss_supervisor.sv
rtl/motor_limit_safety_supervisor_core.sv
dv/tb_motor_limit_safety_supervisor_core.sv
